### rtl/gtp_pkg.sv
package gtp_pkg;

    // text layout
    localparam int unsigned CORE_LEN = 36;
    localparam int unsigned POS_W    = 6;
    localparam int unsigned ACC_W    = 128;

    // dash places inside the core text
    localparam logic [POS_W-1:0] DASH_0 = 6'd8;
    localparam logic [POS_W-1:0] DASH_1 = 6'd13;
    localparam logic [POS_W-1:0] DASH_2 = 6'd18;
    localparam logic [POS_W-1:0] DASH_3 = 6'd23;

    localparam logic [POS_W-1:0] POS_MAX   = 6'd63;
    localparam logic [POS_W-1:0] CORE_LAST = 6'd35;
    localparam logic [POS_W-1:0] CORE_END  = 6'd36;
    localparam logic [POS_W-1:0] CLOSE_POS = 6'd37;

    // character codes
    localparam logic [7:0] CH_OPEN  = 8'h7B;
    localparam logic [7:0] CH_CLOSE = 8'h7D;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] HEX_TEN  = 8'd10;

    // classification of one character
    typedef struct packed {
        logic       is_hex;
        logic [3:0] nibble;
        logic       is_dash;
        logic       is_open;
        logic       is_close;
    } char_class_t;

endpackage

### rtl/gtp_char_decode.sv
module gtp_char_decode (
    input  logic [7:0]          char_code,
    output gtp_pkg::char_class_t cls
);

    logic [7:0] value;

    always_comb begin
        value      = 8'd0;
        cls.is_hex = 1'b0;
        if (char_code >= gtp_pkg::CH_0 && char_code <= gtp_pkg::CH_9) begin
            cls.is_hex = 1'b1;
            value      = char_code - gtp_pkg::CH_0;
        end else if (char_code >= gtp_pkg::CH_LA && char_code <= gtp_pkg::CH_LF) begin
            cls.is_hex = 1'b1;
            value      = char_code - gtp_pkg::CH_LA + gtp_pkg::HEX_TEN;
        end else if (char_code >= gtp_pkg::CH_UA && char_code <= gtp_pkg::CH_UF) begin
            cls.is_hex = 1'b1;
            value      = char_code - gtp_pkg::CH_UA + gtp_pkg::HEX_TEN;
        end
        cls.nibble   = value[3:0];
        cls.is_dash  = (char_code == gtp_pkg::CH_DASH);
        cls.is_open  = (char_code == gtp_pkg::CH_OPEN);
        cls.is_close = (char_code == gtp_pkg::CH_CLOSE);
    end

endmodule

### rtl/guid_text_parser.sv
// guid_text_parser: checks and decodes GUID text, one character per transfer
// the result shows on m_tvalid in the cycle after the last character's transfer
// throughput: one character per cycle; the input stalls while a result waits on m_tready
// the only stall comes from m_tready when the result register is full
// reset: aresetn low clears the position, brace mode, error flag, accumulator and result valid
module guid_text_parser (
    input  logic         aclk,
    input  logic         aresetn,
    // character stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] char_code
    input  logic         s_tlast,   // last_char
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // [31:0] time_low, [47:32] time_mid,
                                    // [63:48] time_high, [127:64] node_bytes
    output logic         m_tuser    // well_formed
);

    localparam int unsigned PW = gtp_pkg::POS_W;

    // parser state
    logic [PW-1:0]             pos_reg, pos_next;
    logic                      braced_reg, braced_next;
    logic                      err_reg, err_next;
    logic [gtp_pkg::ACC_W-1:0] acc_reg, acc_next;

    // result register
    logic         m_valid_reg;
    logic [127:0] m_data_reg;
    logic         m_ok_reg;

    logic                 accept;
    gtp_pkg::char_class_t cls;
    logic [PW-1:0]        q;
    logic                 in_core;
    logic                 dash_here;
    logic                 close_ok;
    logic                 ok;

    gtp_char_decode u_decode (
        .char_code (s_tdata),
        .cls       (cls)
    );

    // result register frees up when empty or being taken
    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        braced_next = braced_reg;
        err_next    = err_reg;
        acc_next    = acc_reg;
        close_ok    = 1'b0;
        q           = pos_reg;
        in_core     = 1'b0;
        dash_here   = 1'b0;

        if (pos_reg == '0 && cls.is_open) begin
            // opening brace only at the very first place
            braced_next = 1'b1;
        end else begin
            if (braced_reg) begin
                q       = pos_reg - 1'b1;
                in_core = (pos_reg >= 6'd1) && (pos_reg <= gtp_pkg::CORE_END);
            end else begin
                q       = pos_reg;
                in_core = (pos_reg < gtp_pkg::CORE_END);
            end
            dash_here = (q == gtp_pkg::DASH_0) || (q == gtp_pkg::DASH_1) ||
                        (q == gtp_pkg::DASH_2) || (q == gtp_pkg::DASH_3);
            if (in_core) begin
                if (dash_here) begin
                    if (!cls.is_dash) err_next = 1'b1;
                end else if (!cls.is_hex) begin
                    err_next = 1'b1;
                end else begin
                    // 128-bit shift, one hex digit in at the bottom
                    acc_next = {acc_reg[gtp_pkg::ACC_W-5:0], cls.nibble};
                end
            end else if (braced_reg && pos_reg == gtp_pkg::CLOSE_POS && cls.is_close) begin
                close_ok = 1'b1;
            end else begin
                // too long, or a stray character outside the core
                err_next = 1'b1;
            end
        end

        // saturating position counter
        pos_next = (pos_reg < gtp_pkg::POS_MAX) ? pos_reg + 1'b1 : pos_reg;

        ok = !err_next && (braced_next ? close_ok : (pos_reg == gtp_pkg::CORE_LAST));

        // the last character ends the text: back to the start state
        if (s_tlast) begin
            pos_next    = '0;
            braced_next = 1'b0;
            err_next    = 1'b0;
            acc_next    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            braced_reg <= 1'b0;
            err_reg    <= 1'b0;
            acc_reg    <= '0;
        end else if (accept) begin
            pos_reg    <= pos_next;
            braced_reg <= braced_next;
            err_reg    <= err_next;
            acc_reg    <= acc_next;
        end
    end

    // result register: loaded by the transfer of a last character
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept && s_tlast) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // repack the accumulator as time_low, time_mid, time_high, node_bytes
    function automatic logic [127:0] q_acc_low(input logic [127:0] acc,
                                               input logic [3:0] nib,
                                               input logic shift);
        logic [127:0] v;
        v = shift ? {acc[123:0], nib} : acc;
        q_acc_low = {v[63:0], v[79:64], v[95:80], v[127:96]};
    endfunction

    always_ff @(posedge aclk) begin
        if (accept && s_tlast) begin
            m_ok_reg <= ok;
            if (ok) begin
                // shifted value before the end-of-text clear
                m_data_reg <= {q_acc_low(acc_reg, cls.nibble, in_core && !dash_here)};
            end else begin
                m_data_reg <= '0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_ok_reg;

endmodule
